@@ hdl/asert_pkg.sv @@
// ----------------------------------------------------------------------------
// asert_pkg: shared constants and types for the target calculation
// Word widths, polynomial coefficients and the pipeline status struct.
// ----------------------------------------------------------------------------
package asert_pkg;
  localparam int TARGET_BITS_DEF = 224;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_BITS = 256;
  localparam int QUO_BITS = 64;
  localparam int DIV_STEPS = 4;
  localparam logic [47:0] COEF1 = 48'd195766423245049;
  localparam logic [31:0] COEF2 = 32'd971821376;
  localparam logic [12:0] COEF3 = 13'd5127;
  localparam logic [15:0] SPACING_RST = 16'd600;
  localparam logic [31:0] HALF_LIFE_RST = 32'd172800;

  typedef enum logic [2:0] {
    REG_SPACING = 3'd0,
    REG_HALF_LIFE = 3'd1,
    REG_LIMIT0 = 3'd2,
    REG_LIMIT1 = 3'd3,
    REG_LIMIT2 = 3'd4,
    REG_LIMIT3 = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic err;
  } stage_ctl_t;
endpackage

@@ hdl/asert_target_calculation.sv @@
// ----------------------------------------------------------------------------
// asert_target_calculation: exponential target schedule
// Exponent, cubic 2^x factor, wide product, shift and clamp.
// ----------------------------------------------------------------------------
// Pipeline: 19 register stages in all, from stage 1 to the output stage.
// Throughput: one request per cycle unless the output stalls; the 8-stage
//   divider, split polynomial and wide multiply stages are fully pipelined.
// Any stall holds the whole pipeline in place.
// Reset: synchronous, clears valid bits and loads register defaults.
module asert_target_calculation #(
  parameter int TARGET_BITS = asert_pkg::TARGET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] ref_target_word0,
  input  logic [63:0] ref_target_word1,
  input  logic [63:0] ref_target_word2,
  input  logic [31:0] ref_target_word3,
  input  logic signed [47:0] elapsed_seconds,
  input  logic [31:0] blocks_since_anchor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] next_target_word0,
  output logic [63:0] next_target_word1,
  output logic [63:0] next_target_word2,
  output logic [31:0] next_target_word3,
  output logic        precondition_error
);
  localparam int W = asert_pkg::WIDE_BITS;

  logic [15:0]  spacing;
  logic [31:0]  decay_period;
  logic [223:0] limit_reg;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= asert_pkg::SPACING_RST;
      decay_period <= asert_pkg::HALF_LIFE_RST;
      limit_reg <= {32'd0, {192{1'b1}}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asert_pkg::REG_SPACING:   spacing <= cfg_data[15:0];
        asert_pkg::REG_HALF_LIFE: decay_period <= cfg_data[31:0];
        asert_pkg::REG_LIMIT0:    limit_reg[63:0] <= cfg_data;
        asert_pkg::REG_LIMIT1:    limit_reg[127:64] <= cfg_data;
        asert_pkg::REG_LIMIT2:    limit_reg[191:128] <= cfg_data;
        asert_pkg::REG_LIMIT3:    limit_reg[223:192] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [W-1:0] lim_w;
  assign lim_w = {32'd0, limit_reg};

  // global advance: hold everything when the output is stalled and full
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: deviation and checks ----------------
  asert_pkg::stage_ctl_t s1;
  logic [223:0] s1_tgt;
  logic signed [49:0] s1_d;
  logic s1_limbad;
  always_ff @(posedge clk) begin
    if (rst) s1.valid <= 1'b0;
    else if (adv) s1.valid <= in_valid;
    if (adv) begin
      s1_tgt <= {ref_target_word3, ref_target_word2, ref_target_word1, ref_target_word0};
      s1_d <= 50'(elapsed_seconds) - $signed({2'b0, 48'(spacing * blocks_since_anchor)})
              - $signed({34'd0, spacing});
      s1_limbad <= (TARGET_BITS < 224) ? |(limit_reg >> TARGET_BITS) : 1'b0;
      s1.err <= 1'b0;
    end
  end

  // ---------------- stage 2: error resolve, magnitude ----------------
  asert_pkg::stage_ctl_t s2;
  logic [223:0] s2_tgt;
  logic [63:0] s2_m;
  logic s2_neg;
  logic signed [50:0] s1_dev;
  logic s1_err;
  always_comb begin
    s1_dev = 51'(s1_d) + 51'($signed({34'd0, spacing}));
    s1_err = (decay_period == '0) || (s1_tgt == '0) || (s1_tgt > limit_reg) || s1_limbad ||
             (s1_dev >= 51'sd140737488355328) || (s1_dev <= -51'sd140737488355328);
  end
  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else if (adv) s2.valid <= s1.valid;
    if (adv) begin
      s2.err <= s1_err;
      s2_tgt <= s1_tgt;
      s2_neg <= s1_d[49];
      s2_m <= {(s1_d[49] ? 48'(-s1_d) : 48'(s1_d)), 16'd0};
    end
  end

  // ---------------- divider stages ----------------
  localparam int SB = 1 + 1 + 224;
  logic dq_valid;
  logic [63:0] dq;
  logic [SB-1:0] dside;
  asert_divider #(.SIDE_BITS(SB)) u_div (
    .clk(clk), .rst(rst), .advance(adv), .in_valid(s2.valid),
    .dividend(s2_m), .divisor(decay_period), .side_in({s2.err, s2_neg, s2_tgt}),
    .out_valid(dq_valid), .quotient(dq), .side_out(dside)
  );

  // ---------------- stage 3: shift count and fraction ----------------
  asert_pkg::stage_ctl_t s3;
  logic [223:0] s3_tgt;
  logic signed [49:0] s3_shift;
  logic [15:0] s3_f;
  always_ff @(posedge clk) begin
    if (rst) s3.valid <= 1'b0;
    else if (adv) s3.valid <= dq_valid;
    if (adv) begin
      s3.err <= dside[SB-1];
      s3_tgt <= dside[223:0];
      if (!dside[224]) begin
        s3_shift <= $signed({2'b0, dq[63:16]}) - 50'sd16;
        s3_f <= dq[15:0];
      end else begin
        s3_shift <= -$signed({2'b0, dq[63:16]}) - 50'($signed({1'b0, |dq[15:0]})) - 50'sd16;
        s3_f <= 16'(-dq[15:0]);
      end
    end
  end

  // ---------------- stage 4: f^2, c1*f ----------------
  asert_pkg::stage_ctl_t s4;
  logic [223:0] s4_tgt;
  logic signed [49:0] s4_shift;
  logic [15:0] s4_f;
  logic [31:0] s4_f2;
  logic [63:0] s4_t1;
  always_ff @(posedge clk) begin
    if (rst) s4.valid <= 1'b0;
    else if (adv) s4.valid <= s3.valid;
    if (adv) begin
      s4.err <= s3.err; s4_tgt <= s3_tgt; s4_shift <= s3_shift; s4_f <= s3_f;
      s4_f2 <= s3_f * s3_f;
      s4_t1 <= 64'(asert_pkg::COEF1 * s3_f);
    end
  end

  // ---------------- stage 5: c2*f^2, f^2*f ----------------
  asert_pkg::stage_ctl_t s5;
  logic [223:0] s5_tgt;
  logic signed [49:0] s5_shift;
  logic [63:0] s5_t1, s5_t2, s5_t3a;
  always_ff @(posedge clk) begin
    if (rst) s5.valid <= 1'b0;
    else if (adv) s5.valid <= s4.valid;
    if (adv) begin
      s5.err <= s4.err; s5_tgt <= s4_tgt; s5_shift <= s4_shift; s5_t1 <= s4_t1;
      s5_t2 <= 64'(asert_pkg::COEF2 * s4_f2);
      s5_t3a <= 64'(s4_f2 * s4_f);
    end
  end

  // ---------------- stage 6: c3 term, c1 and c2 sum ----------------
  asert_pkg::stage_ctl_t s6;
  logic [223:0] s6_tgt;
  logic signed [49:0] s6_shift;
  logic [63:0] s6_sum, s6_t3;
  always_ff @(posedge clk) begin
    if (rst) s6.valid <= 1'b0;
    else if (adv) s6.valid <= s5.valid;
    if (adv) begin
      s6.err <= s5.err; s6_tgt <= s5_tgt; s6_shift <= s5_shift;
      s6_sum <= s5_t1 + s5_t2 + 64'h0000_8000_0000_0000;
      s6_t3 <= 64'(s5_t3a[47:0] * asert_pkg::COEF3);
    end
  end

  // ---------------- stage 7: factor ----------------
  asert_pkg::stage_ctl_t s7;
  logic [223:0] s7_tgt;
  logic signed [49:0] s7_shift;
  logic [31:0] s7_fac;
  logic [63:0] poly;
  assign poly = s6_sum + s6_t3;
  always_ff @(posedge clk) begin
    if (rst) s7.valid <= 1'b0;
    else if (adv) s7.valid <= s6.valid;
    if (adv) begin
      s7.err <= s6.err; s7_tgt <= s6_tgt; s7_shift <= s6_shift;
      s7_fac <= 32'h0001_0000 + {16'd0, poly[63:48]};
    end
  end

  // ---------------- stage 8: partial products (7 x 32x32) ----------------
  asert_pkg::stage_ctl_t s8;
  logic signed [49:0] s8_shift;
  logic [63:0] s8_pp [7];
  always_ff @(posedge clk) begin
    if (rst) s8.valid <= 1'b0;
    else if (adv) s8.valid <= s7.valid;
    if (adv) begin
      s8.err <= s7.err; s8_shift <= s7_shift;
      for (int i = 0; i < 7; i++) s8_pp[i] <= s7_tgt[i*32 +: 32] * s7_fac;
    end
  end

  // ---------------- stage 9: accumulate ----------------
  asert_pkg::stage_ctl_t s9;
  logic signed [49:0] s9_shift;
  logic [W-1:0] s9_prod;
  logic [W-1:0] acc;
  // even and odd partial products do not overlap, so one add suffices
  assign acc = {s8_pp[6], s8_pp[4], s8_pp[2], s8_pp[0]}
             + {32'd0, s8_pp[5], s8_pp[3], s8_pp[1], 32'd0};
  always_ff @(posedge clk) begin
    if (rst) s9.valid <= 1'b0;
    else if (adv) s9.valid <= s8.valid;
    if (adv) begin
      s9.err <= s8.err; s9_shift <= s8_shift; s9_prod <= acc;
    end
  end

  // ---------------- stage 10: shift and overflow ----------------
  asert_pkg::stage_ctl_t s10;
  logic [W-1:0] s10_v;
  logic [W-1:0] shv;
  always_comb begin
    logic [W-1:0] lost;
    shv = '0;
    lost = '0;
    if (s9_shift <= 0) begin
      if (s9_shift > -50'sd256) shv = s9_prod >> 8'(-s9_shift);
    end else if (s9_prod != '0) begin
      lost = (s9_shift >= 50'sd256) ? s9_prod : (s9_prod >> (9'd256 - 9'(s9_shift)));
      shv = (lost != '0) ? lim_w : (s9_prod << 8'(s9_shift));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s10.valid <= 1'b0;
    else if (adv) s10.valid <= s9.valid;
    if (adv) begin
      s10.err <= s9.err; s10_v <= shv;
    end
  end

  // ---------------- output stage: clamp ----------------
  logic [W-1:0] res;
  logic o_err;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s10.valid;
    if (adv) begin
      o_err <= s10.err;
      if (s10.err) res <= '0;
      else if (s10_v == '0) res <= W'(1);
      else if (s10_v > lim_w) res <= lim_w;
      else res <= s10_v;
    end
  end

  assign next_target_word0 = res[63:0];
  assign next_target_word1 = res[127:64];
  assign next_target_word2 = res[191:128];
  assign next_target_word3 = res[223:192];
  assign precondition_error = o_err;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res))
    else $error("result changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_err |-> res == '0)
    else $error("error result not zero");
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !o_err |-> res != '0)
    else $error("zero target produced");
endmodule

@@ hdl/asert_divider.sv @@
// ----------------------------------------------------------------------------
// asert_divider: pipelined restoring divider
// Divides a 64-bit value by a 32-bit divisor, a fixed number of bits per
// stage, carrying the side payload along.
// ----------------------------------------------------------------------------
module asert_divider #(
  parameter int SIDE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  logic [63:0]           dividend,
  input  logic [31:0]           divisor,
  input  logic [SIDE_BITS-1:0]  side_in,
  output logic                  out_valid,
  output logic [63:0]           quotient,
  output logic [SIDE_BITS-1:0]  side_out
);
  localparam int STAGES = 8;
  localparam int BPS = 64 / STAGES;

  logic [STAGES:0]        vld;
  logic [63:0]            num [STAGES+1];
  logic [32:0]            rem [STAGES+1];
  logic [31:0]            dv  [STAGES+1];
  logic [SIDE_BITS-1:0]   sd  [STAGES+1];

  assign vld[0] = in_valid;
  assign num[0] = dividend;
  assign rem[0] = '0;
  assign dv[0]  = divisor;
  assign sd[0]  = side_in;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [63:0] n_next;
    logic [32:0] r_next;
    always_comb begin
      logic [32:0] r;
      logic [63:0] n;
      r = rem[s];
      n = num[s];
      for (int b = 0; b < BPS; b++) begin
        r = {r[31:0], n[63]};
        n = {n[62:0], 1'b0};
        if (r >= {1'b0, dv[s]}) begin
          r = r - {1'b0, dv[s]};
          n[0] = 1'b1;
        end
      end
      n_next = n;
      r_next = r;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
      if (advance) begin
        num[s+1] <= n_next;
        rem[s+1] <= r_next;
        dv[s+1]  <= dv[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quotient  = num[STAGES];
  assign side_out  = sd[STAGES];
endmodule
